@@ design/spr_pkg.sv @@
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants for the stepper ramp pulse controller.
// ----------------------------------------------------------------------------
package spr_pkg;

	localparam logic [11:0] FREQ_MIN     = 12'd500;
	localparam logic [11:0] FREQ_MAX     = 12'd3000;
	localparam logic [11:0] FREQ_RESET   = 12'd2000;
	localparam int          DIV_BITS     = 17;
	localparam int          DIV_IDX_W    = $clog2(DIV_BITS);
	localparam logic [DIV_BITS-1:0] TIMER_BASE = 17'd100000;
	localparam logic [31:0] TARGET_RESET = 32'd10000000;
	localparam logic [6:0]  STEP_RESET   = 7'd5;

	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_SET   = 3'd1;
	localparam logic [2:0] CMD_START = 3'd2;
	localparam logic [2:0] CMD_STOP  = 3'd3;
	localparam logic [2:0] CMD_CLEAR = 3'd4;
	localparam logic [2:0] CMD_POLL  = 3'd5;

	localparam logic REG_TARGET = 1'b0;
	localparam logic REG_STEP   = 1'b1;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] speed_hz;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  reload_value;
		logic [6:0]  compare_value;
		logic [11:0] current_freq;
		logic        is_running;
		logic        is_ramping;
		logic [31:0] pulses_sent;
		logic        reached;
	} out_word_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic take;
		logic exec;
		logic div_step;
		logic load_out;
	} ctl_t;

	typedef struct packed {
		logic div_last;
	} sts_t;

endpackage

@@ design/stepper_ramp_pulse_controller_unit.sv @@
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_controller_unit
// Step-pulse frequency controller with linear ramp and register port.
// ----------------------------------------------------------------------------
// Each input word is one command (tick, set speed, start, stop, clear count,
// poll) and yields one result word with the timer reload and compare values,
// present frequency, flags, pulse count and reached flag. A command passes
// from accept to result in order: latch the word, update the motor state,
// run the bit-serial divide of 100000 by the frequency, then load the result
// register, which waits while a held result is stalled. A new word is taken
// as soon as the previous one has been moved into the result register.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_controller_unit import spr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_word,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] target_q;
	logic [6:0]  step_q;
	ctl_t        ctl;
	sts_t        sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
			step_q   <= STEP_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_TARGET: target_q <= pwdata;
				REG_STEP:   step_q   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TARGET: prdata = target_q;
			REG_STEP:   prdata = {25'd0, step_q};
			default:    prdata = '0;
		endcase
	end

	spr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	spr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.target    (target_q),
		.ramp_step (step_q),
		.ctl       (ctl),
		.sts       (sts),
		.out_word  (out_word)
	);

endmodule

@@ design/spr_dp.sv @@
// ----------------------------------------------------------------------------
// spr_dp
// Datapath: command latch, motor state, serial period divider, result word.
// ----------------------------------------------------------------------------
module spr_dp import spr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  in_word_t    in_word,
	input  logic [31:0] target,
	input  logic [6:0]  ramp_step,
	input  ctl_t        ctl,
	output sts_t        sts,
	output out_word_t   out_word
);

	logic [2:0]           cmd_q;
	logic [15:0]          speed_q;
	logic                 running_q, ramping_q, reached_q, reach_out_q;
	logic [11:0]          freq_q, goal_q, last_q;
	logic [31:0]          count_q;
	logic [11:0]          rem_q;
	logic [7:0]           quo_q;
	logic [DIV_IDX_W-1:0] bit_q;
	out_word_t            out_q;

	logic        run_n, ramp_n, reach_n, skip;
	logic [11:0] freq_n, goal_n, last_n, spd_c, diff, step_ext;
	logic [12:0] sum;
	logic [31:0] cnt_n;
	logic [12:0] trial;
	logic        fits;

	assign step_ext = {5'd0, ramp_step};
	assign sum      = {1'b0, freq_q} + {6'd0, ramp_step};
	assign diff     = freq_q - goal_q;

	always_comb begin
		if (speed_q < {4'd0, FREQ_MIN})
			spd_c = FREQ_MIN;
		else if (speed_q > {4'd0, FREQ_MAX})
			spd_c = FREQ_MAX;
		else
			spd_c = speed_q[11:0];
	end

	always_comb begin
		run_n   = running_q;
		ramp_n  = ramping_q;
		reach_n = reached_q;
		freq_n  = freq_q;
		goal_n  = goal_q;
		last_n  = last_q;
		cnt_n   = count_q;
		skip    = 1'b0;
		case (cmd_q)
			CMD_TICK: begin
				if (running_q) begin
					cnt_n = count_q + 32'd1;
					if (ramping_q) begin
						if (freq_q < goal_q) begin
							freq_n = (sum > {1'b0, goal_q}) ? goal_q : sum[11:0];
						end else if (freq_q > goal_q) begin
							freq_n = (diff < step_ext) ? goal_q : freq_q - step_ext;
						end
						if (freq_n == goal_q) begin
							ramp_n = 1'b0;
							if (goal_q == FREQ_MIN) begin
								run_n = 1'b0;
								skip  = 1'b1;
							end
						end
					end
					if (!skip && !reached_q && cnt_n >= target)
						reach_n = 1'b1;
				end
			end
			CMD_SET: begin
				last_n = spd_c;
				if (running_q) begin
					goal_n = spd_c;
					ramp_n = 1'b1;
				end else begin
					freq_n = spd_c;
				end
			end
			CMD_START: begin
				if (!running_q) begin
					run_n  = 1'b1;
					freq_n = FREQ_MIN;
					goal_n = last_q;
					ramp_n = 1'b1;
				end
			end
			CMD_STOP: begin
				if (running_q) begin
					goal_n = FREQ_MIN;
					ramp_n = 1'b1;
				end
			end
			CMD_CLEAR: cnt_n = '0;
			default: ;
		endcase
	end

	// restoring division of the timer base by the present frequency
	assign trial = {rem_q, TIMER_BASE[bit_q]};
	assign fits  = trial >= {1'b0, freq_q};
	assign sts.div_last = (bit_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			ramping_q <= 1'b0;
			reached_q <= 1'b0;
			freq_q    <= FREQ_RESET;
			goal_q    <= FREQ_RESET;
			last_q    <= FREQ_RESET;
			count_q   <= '0;
		end else if (ctl.exec) begin
			running_q <= run_n;
			ramping_q <= ramp_n;
			reached_q <= (cmd_q == CMD_POLL) ? 1'b0 : reach_n;
			freq_q    <= freq_n;
			goal_q    <= goal_n;
			last_q    <= last_n;
			count_q   <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q   <= in_word.cmd;
			speed_q <= in_word.speed_hz;
		end
		if (ctl.exec) begin
			reach_out_q <= reach_n;
			rem_q       <= '0;
			quo_q       <= '0;
			bit_q       <= DIV_IDX_W'(DIV_BITS - 1);
		end else if (ctl.div_step) begin
			rem_q <= fits ? 12'(trial - {1'b0, freq_q}) : trial[11:0];
			quo_q <= {quo_q[6:0], fits};
			bit_q <= bit_q - 1'b1;
		end
		if (ctl.load_out) begin
			out_q.reload_value  <= quo_q - 8'd1;
			out_q.compare_value <= quo_q[7:1];
			out_q.current_freq  <= freq_q;
			out_q.is_running    <= running_q;
			out_q.is_ramping    <= ramping_q;
			out_q.pulses_sent   <= count_q;
			out_q.reached       <= reach_out_q;
		end
	end

	assign out_word = out_q;

endmodule

@@ design/spr_ctrl.sv @@
// ----------------------------------------------------------------------------
// spr_ctrl
// Controller: sequences accept, execute, divide and result handoff.
// ----------------------------------------------------------------------------
module spr_ctrl import spr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q, state_n;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctl.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_n  = state_q;
		ctl      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.take = 1'b1;
					state_n  = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				state_n  = S_DIV;
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_last)
					state_n = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					ctl.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
